@@ rtl/rpc_pkg.sv @@
// -----------------------------------------------------------------------------
// rpc_pkg - shared types and constants for the rectangular/polar converter
// Fixed-point formats, pipeline word types, CORDIC angle table and gain.
// -----------------------------------------------------------------------------
package rpc_pkg;

	// Q formats
	localparam int FRAC_BITS  = 16;          // fraction bits of the angle fields
	localparam int GUARD_BITS = 16;          // extra fraction bits in the datapath
	localparam int ANGLE_Q    = 40;          // fraction bits of the angle accumulator
	localparam int ANG_SH     = ANGLE_Q - FRAC_BITS;

	// datapath widths
	localparam int DW    = 51;               // x/y: 32-bit input << 16, gain and sign headroom
	localparam int ZW    = 50;               // angle accumulator, +-280 deg in Q40
	localparam int AW    = 27;               // angle in Q16 degrees with fold headroom
	localparam int INV_W = 30;               // inverse CORDIC gain, Q30

	localparam logic signed [AW-1:0] ANG_QTR  = AW'(90 <<< FRAC_BITS);
	localparam logic signed [AW-1:0] ANG_HALF = AW'(180 <<< FRAC_BITS);
	localparam logic signed [AW-1:0] ANG_FULL = AW'(360 <<< FRAC_BITS);
	localparam logic signed [ZW-1:0] Z_HALF   = ZW'(64'd180 << ANGLE_Q);

	// integer part of the angle modulo: h / 360 as (h * 46604) >> 24, exact for h < 2^16
	localparam int          DEG_TURN   = 360;
	localparam logic [15:0] RECIP_TURN = 16'd46604;
	localparam int          RECIP_SH   = 24;

	// degrees per radian as a decimal fraction
	localparam logic [63:0] DEG_NUM = 64'd572957795130823;
	localparam logic [63:0] DEG_DEN = 64'd10000000000000;
	localparam logic [63:0] DEG_INT = DEG_NUM / DEG_DEN;
	localparam logic [63:0] DEG_REM = DEG_NUM % DEG_DEN;

	typedef enum logic {
		OP_RECT  = 1'b0,
		OP_POLAR = 1'b1
	} rpc_op_t;

	// word moving through the CORDIC pipeline
	typedef struct packed {
		rpc_op_t              op;
		logic                 zero;   // rectangular zero vector
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic signed [31:0]   pa;     // first value, passed along
		logic signed [31:0]   pb;     // second value, or reduced angle in polar mode
	} rpc_vec_t;

	typedef struct packed {
		logic signed [24:0] ang;
		logic signed [32:0] mag;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} rpc_res_t;

	// elaboration-time helpers below

	function automatic logic [63:0] rpc_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] rpc_deg_per_rad_q56();
		logic [63:0] q;
		logic [63:0] r;
		q = DEG_INT;
		r = DEG_REM;
		for (int i = 0; i < 56; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= DEG_DEN) begin
				r    = r - DEG_DEN;
				q[0] = 1'b1;
			end
		end
		if ((r << 1) >= DEG_DEN)
			q = q + 64'd1;
		return q;
	endfunction

	// atan(2^-idx) in degrees, Q40, from the arctangent series
	function automatic logic [63:0] rpc_atan_q40(input int idx);
		logic [63:0]        q;
		logic [63:0]        term;
		logic signed [63:0] sum;
		int                 sh;
		q   = rpc_deg_per_rad_q56();
		sum = '0;
		for (int k = 0; k < 32; k++) begin
			sh = idx * (2 * k + 1);
			if (sh < 64) begin
				term = rpc_udiv(q >> sh, 64'(2 * k + 1));
				if (k[0])
					sum = sum - $signed(term);
				else
					sum = sum + $signed(term);
			end
		end
		if (idx == 0)
			return 64'd45 << ANGLE_Q;
		return 64'((sum + 64'sd32768) >>> 16);
	endfunction

	function automatic logic [63:0] rpc_isqrt(input logic [63:0] n);
		logic [63:0] num;
		logic [63:0] res;
		logic [63:0] bit_v;
		num   = n;
		res   = '0;
		bit_v = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (num >= res + bit_v) begin
				num = num - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// 1/K for a given iteration count, Q30
	function automatic logic [63:0] rpc_inv_gain_q30(input int iters);
		logic [63:0] p;
		logic [63:0] r;
		p = 64'd1 << 60;
		for (int i = 0; i < 32; i++) begin
			if (i < iters)
				p = p + (p >> (2 * i));
		end
		r = rpc_isqrt(p);
		return rpc_udiv((64'd1 << 60) + (r >> 1), r);
	endfunction

endpackage

@@ rtl/rpc_gain.sv @@
// -----------------------------------------------------------------------------
// rpc_gain - inverse CORDIC gain on x of SCALE_OP words, others passed unchanged
// Two stages: split 32-bit partial products, then rounded sum and sign.
// -----------------------------------------------------------------------------
module rpc_gain
	import rpc_pkg::*;
#(
	parameter int      ITERS    = 16,
	parameter rpc_op_t SCALE_OP = OP_RECT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rpc_vec_t in_vec,
	output logic     out_valid,
	input  logic     out_ready,
	output rpc_vec_t out_vec
);

	localparam logic [63:0]      INV_FULL = rpc_inv_gain_q30(ITERS);
	localparam logic [INV_W-1:0] INV_GAIN = INV_W'(INV_FULL);
	localparam int HW       = DW - 32;
	localparam int PHW      = HW + INV_W;
	localparam int PLW      = 32 + INV_W;
	localparam int SPLIT_SH = 32 - INV_W;
	localparam logic [PLW:0] RND_INV = (PLW + 1)'(1) << (INV_W - 1);

	logic                 v_s1, v_s2;
	logic                 ld1, ld2;
	rpc_vec_t             vec_s1, vec_s2;
	logic                 neg_s1, apply_s1;
	logic [PHW-1:0]       phi_s1;
	logic [PLW-1:0]       plo_s1;

	logic signed [DW-1:0] xi;
	logic [DW-1:0]        xmag;
	logic [PLW:0]         lo_rnd;
	logic [DW-1:0]        res;
	logic signed [DW-1:0] scaled;
	rpc_vec_t             nxt;

	assign ld2      = !v_s2 || out_ready;
	assign ld1      = !v_s1 || ld2;
	assign in_ready = ld1;

	assign xi   = $signed(in_vec.x);
	assign xmag = xi[DW-1] ? DW'(-xi) : DW'(xi);

	always_comb begin
		lo_rnd = (PLW + 1)'(plo_s1) + RND_INV;
		res    = (DW'(phi_s1) << SPLIT_SH) + DW'(lo_rnd >> INV_W);
		scaled = neg_s1 ? -$signed(res) : $signed(res);
		nxt    = vec_s1;
		if (apply_s1)
			nxt.x = scaled;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1)
				v_s1 <= in_valid;
			if (ld2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			vec_s1   <= in_vec;
			neg_s1   <= xi[DW-1];
			apply_s1 <= (in_vec.op == SCALE_OP);
			phi_s1   <= PHW'(xmag[DW-1:32]) * PHW'(INV_GAIN);
			plo_s1   <= PLW'(xmag[31:0]) * PLW'(INV_GAIN);
		end
		if (ld2)
			vec_s2 <= nxt;
	end

	assign out_valid = v_s2;
	assign out_vec   = vec_s2;

endmodule

@@ rtl/rpc_prep.sv @@
// -----------------------------------------------------------------------------
// rpc_prep - input staging for the CORDIC
// Polar angle reduction and quadrant fold, rectangular half-plane flip,
// then the inverse gain on the polar magnitude.
// -----------------------------------------------------------------------------
module rpc_prep
	import rpc_pkg::*;
#(
	parameter int ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rpc_op_t            in_op,
	input  logic signed [31:0] in_a,
	input  logic signed [31:0] in_b,
	output logic               out_valid,
	input  logic               out_ready,
	output rpc_vec_t           out_vec
);

	localparam logic [16:0] TURN17 = 17'(DEG_TURN);

	logic               v_s1, v_s2, v_s3;
	logic               ld1, ld2, ld3, g_ready;
	rpc_op_t            op_s1, op_s2;
	logic signed [31:0] a_s1, b_s1, a_s2, b_s2;
	logic               neg_s1;
	logic [15:0]        h_s1, frac_s1;
	logic [31:0]        prod_s1;
	logic signed [AW-1:0] r_s2;
	rpc_vec_t           vec_s3;

	logic [31:0]          bmag;
	logic [31-RECIP_SH:0] quo;
	logic [16:0]          rem0, rem;
	logic signed [AW-1:0] rmag, r_n;
	logic signed [AW-1:0] r1, zr;
	logic                 xneg;
	logic signed [DW-1:0] x0, y0;
	rpc_vec_t             nv;

	assign ld3      = !v_s3 || g_ready;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_ready = ld1;

	// stage 1: |angle| split into whole degrees and fraction
	assign bmag = in_b[31] ? 32'(-in_b) : 32'(in_b);

	// stage 2: |angle| mod 360, sign restored (truncating remainder)
	always_comb begin
		quo  = prod_s1[31:RECIP_SH];
		rem0 = 17'(h_s1) - 17'(17'(quo) * TURN17);
		rem  = (rem0 >= TURN17) ? rem0 - TURN17 : rem0;
		rmag = $signed(AW'({rem[8:0], frac_s1}));
		r_n  = neg_s1 ? -rmag : rmag;
	end

	// stage 3: polar angle folded into (-180,180], then into +-90 with x flipped; rectangular half-plane flip
	always_comb begin
		r1 = r_s2;
		if (r1 > ANG_HALF)
			r1 = r1 - ANG_FULL;
		if (r1 <= -ANG_HALF)
			r1 = r1 + ANG_FULL;
		zr   = r1;
		xneg = 1'b0;
		if (r1 > ANG_QTR) begin
			xneg = 1'b1;
			zr   = r1 - ANG_HALF;
		end else if (r1 < -ANG_QTR) begin
			xneg = 1'b1;
			zr   = r1 + ANG_HALF;
		end

		x0 = DW'(a_s2) <<< GUARD_BITS;
		y0 = DW'(b_s2) <<< GUARD_BITS;

		nv.op   = op_s2;
		nv.pa   = a_s2;
		if (op_s2 == OP_POLAR) begin
			nv.zero = 1'b0;
			nv.x    = xneg ? -x0 : x0;
			nv.y    = '0;
			nv.z    = ZW'(zr) <<< ANG_SH;
			nv.pb   = 32'(r1);
		end else begin
			nv.zero = (a_s2 == 32'sd0) && (b_s2 == 32'sd0);
			nv.pb   = b_s2;
			if (a_s2[31]) begin
				nv.x = -x0;
				nv.y = -y0;
				nv.z = b_s2[31] ? -Z_HALF : Z_HALF;
			end else begin
				nv.x = x0;
				nv.y = y0;
				nv.z = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld1)
				v_s1 <= in_valid;
			if (ld2)
				v_s2 <= v_s1;
			if (ld3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			op_s1   <= in_op;
			a_s1    <= in_a;
			b_s1    <= in_b;
			neg_s1  <= in_b[31];
			h_s1    <= bmag[31:16];
			frac_s1 <= bmag[15:0];
			prod_s1 <= 32'(bmag[31:16]) * 32'(RECIP_TURN);
		end
		if (ld2) begin
			op_s2 <= op_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			r_s2  <= r_n;
		end
		if (ld3)
			vec_s3 <= nv;
	end

	rpc_gain #(
		.ITERS    (ITERS),
		.SCALE_OP (OP_POLAR)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (g_ready),
		.in_vec    (vec_s3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_vec   (out_vec)
	);

endmodule

@@ rtl/rpc_stage.sv @@
// -----------------------------------------------------------------------------
// rpc_stage - one CORDIC micro-rotation
// Rotation mode steers on the sign of z, vectoring mode on the sign of y.
// -----------------------------------------------------------------------------
module rpc_stage
	import rpc_pkg::*;
#(
	parameter int STAGE_IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rpc_vec_t in_vec,
	output logic     out_valid,
	input  logic     out_ready,
	output rpc_vec_t out_vec
);

	localparam logic signed [ZW-1:0] ATAN = ZW'(rpc_atan_q40(STAGE_IDX));

	logic                 v_s1, ld;
	rpc_vec_t             vec_s1, nxt;
	logic signed [DW-1:0] xi, yi, xs, ys;
	logic signed [ZW-1:0] zi;
	logic                 ccw;

	assign ld       = !v_s1 || out_ready;
	assign in_ready = ld;

	always_comb begin
		xi  = $signed(in_vec.x);
		yi  = $signed(in_vec.y);
		zi  = $signed(in_vec.z);
		xs  = xi >>> STAGE_IDX;
		ys  = yi >>> STAGE_IDX;
		ccw = (in_vec.op == OP_POLAR) ? !zi[ZW-1] : yi[DW-1];
		nxt = in_vec;
		if (ccw) begin
			nxt.x = xi - ys;
			nxt.y = yi + xs;
			nxt.z = zi - ATAN;
		end else begin
			nxt.x = xi + ys;
			nxt.y = yi - xs;
			nxt.z = zi + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (ld)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ld)
			vec_s1 <= nxt;
	end

	assign out_valid = v_s1;
	assign out_vec   = vec_s1;

endmodule

@@ rtl/rpc_post.sv @@
// -----------------------------------------------------------------------------
// rpc_post - output staging after the CORDIC
// Gain on the vectoring magnitude, rounding, angle fold, saturation.
// -----------------------------------------------------------------------------
module rpc_post
	import rpc_pkg::*;
#(
	parameter int ITERS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rpc_vec_t in_vec,
	output logic     out_valid,
	input  logic     out_ready,
	output rpc_res_t out_res
);

	localparam logic signed [DW-1:0] RND_G = DW'(1) <<< (GUARD_BITS - 1);
	localparam logic signed [ZW-1:0] RND_Z = ZW'(1) <<< (ANG_SH - 1);

	function automatic logic signed [31:0] sat32(input logic signed [DW-1:0] v);
		logic fits;
		fits = (&v[DW-1:31]) || !(|v[DW-1:31]);
		if (fits)
			return v[31:0];
		return v[DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

	logic                 g_valid, ld1;
	rpc_vec_t             g_vec;
	logic                 v_s1;
	rpc_res_t             res_s1, nr;
	logic signed [DW-1:0] xr, yr;
	logic signed [ZW-1:0] zr;
	logic signed [AW-1:0] ar;

	assign ld1 = !v_s1 || out_ready;

	rpc_gain #(
		.ITERS    (ITERS),
		.SCALE_OP (OP_RECT)
	) u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_vec    (in_vec),
		.out_valid (g_valid),
		.out_ready (ld1),
		.out_vec   (g_vec)
	);

	always_comb begin
		xr = ($signed(g_vec.x) + RND_G) >>> GUARD_BITS;
		yr = ($signed(g_vec.y) + RND_G) >>> GUARD_BITS;
		zr = ($signed(g_vec.z) + RND_Z) >>> ANG_SH;
		ar = AW'(zr);
		if (ar > ANG_HALF)
			ar = ar - ANG_FULL;
		if (ar <= -ANG_HALF)
			ar = ar + ANG_FULL;

		if (g_vec.op == OP_POLAR) begin
			nr.x   = sat32(xr);
			nr.y   = sat32(yr);
			nr.mag = 33'($signed(g_vec.pa));
			nr.ang = g_vec.pb[24:0];
		end else begin
			nr.x   = g_vec.pa;
			nr.y   = g_vec.pb;
			nr.mag = g_vec.zero ? '0 : xr[32:0];
			nr.ang = g_vec.zero ? '0 : ar[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (ld1)
			v_s1 <= g_valid;
	end

	always_ff @(posedge clk) begin
		if (ld1)
			res_s1 <= nr;
	end

	assign out_valid = v_s1;
	assign out_res   = res_s1;

endmodule

@@ rtl/rect_polar_converter_top.sv @@
// -----------------------------------------------------------------------------
// rect_polar_converter_top - pipelined CORDIC rectangular/polar converter
// Rectangular words give magnitude and atan2 angle in degrees; polar words
// give saturated x = m*cos, y = m*sin. x and y signed Q16.16, magnitude Q17.16, angle Q9.16.
// -----------------------------------------------------------------------------
//
//  port group  | dir | width | contents (lsb first)
//  ------------+-----+-------+---------------------------------------------------
//  s_axis      | in  | 64+1  | tdata: first_value[31:0], second_value[31:0]
//              |     |       | tuser: op (0 rectangular, 1 polar)
//  m_axis      | out | 128   | tdata: x_out[31:0], y_out[31:0],
//              |     |       |        magnitude_out[32:0], angle_out_deg[24:0], 0 pad
//
//  Pipeline: 3 prep stages, 2 gain stages, one stage per CORDIC iteration,
//  2 gain stages, 1 output register. One word per cycle in and out while
//  m_axis is not stalled; each iteration owns its own adder stage.
//  arst_n clears every stage valid; payload registers are not reset.
//  Each stage loads when it is empty or the next one loads, so bubbles close
//  up behind a held output word and s_axis_tready stays high while m_axis is empty.
//
module rect_polar_converter_top
	import rpc_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = 16   // 8..32
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // first_value, second_value
	input  logic         s_axis_tuser,   // op
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata    // x_out, y_out, magnitude_out, angle_out_deg
);

	// pipeline links: index 0 is the prep output, index N feeds the post block
	rpc_vec_t vec_c [CORDIC_ITERATIONS+1];
	logic     vld_c [CORDIC_ITERATIONS+1];
	logic     rdy_c [CORDIC_ITERATIONS+1];
	rpc_res_t res;

	// front end: angle reduction / half-plane flip, polar magnitude gain
	rpc_prep #(
		.ITERS (CORDIC_ITERATIONS)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (rpc_op_t'(s_axis_tuser)),
		.in_a      ($signed(s_axis_tdata[31:0])),
		.in_b      ($signed(s_axis_tdata[63:32])),
		.out_valid (vld_c[0]),
		.out_ready (rdy_c[0]),
		.out_vec   (vec_c[0])
	);

	// one micro-rotation per stage
	for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cordic
		rpc_stage #(
			.STAGE_IDX (g)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[g]),
			.in_ready  (rdy_c[g]),
			.in_vec    (vec_c[g]),
			.out_valid (vld_c[g+1]),
			.out_ready (rdy_c[g+1]),
			.out_vec   (vec_c[g+1])
		);
	end

	// back end: vectoring magnitude gain, rounding, fold, saturation
	rpc_post #(
		.ITERS (CORDIC_ITERATIONS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_c[CORDIC_ITERATIONS]),
		.in_ready  (rdy_c[CORDIC_ITERATIONS]),
		.in_vec    (vec_c[CORDIC_ITERATIONS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {6'b0, res.ang, res.mag, res.y, res.x};

endmodule

@@ rtl/rpc_checker.sv @@
// -----------------------------------------------------------------------------
// rpc_checker - port-level checks for the rectangular/polar converter
// Reset, output hold under stall, input ready, angle range.
// -----------------------------------------------------------------------------
module rpc_checker
	import rpc_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);

	// no result word while reset is held (valid may still be unknown at the first edge)
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> (m_axis_tvalid !== 1'b1))
		else $error("m_axis_tvalid high during reset");

	// held result word keeps its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// free output slot means the pipe can take a word
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input stalled with room at the output");

	// angle field within (-180,180] degrees
	a_ang_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[121:97]) <= ANG_HALF) &&
			($signed(m_axis_tdata[121:97]) > -ANG_HALF))
		else $error("angle out of range");

endmodule

bind rect_polar_converter_top rpc_checker u_rpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/tb_rect_polar_converter_top.sv @@
// -----------------------------------------------------------------------------
// tb_rect_polar_converter_top - self-checking bench for the CORDIC converter
// Feeds rectangular and polar words through the s_axis stream, predicts each
// result with an independent bit-exact CORDIC model and checks every m_axis
// word field by field, in order, under several sender/receiver idle mixes.
// -----------------------------------------------------------------------------
module tb_rect_polar_converter_top
	import rpc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITERS      = 16;
	localparam int LATENCY    = ITERS + 8;   // prep + gain + iterations + gain + output reg
	localparam int WDOG_LIMIT = 5000;        // cycles with no word moving on either side
	localparam int PHASE_WORDS = 406;        // random words per idle phase

	// angle limits at the output scale and in the Q40 accumulator
	localparam longint HALF_TURN = 64'sd180 <<< FRAC_BITS;
	localparam longint FULL_TURN = 64'sd360 <<< FRAC_BITS;
	localparam longint QTR_Z     = 64'sd90 <<< ANGLE_Q;
	localparam longint HALF_Z    = 64'sd180 <<< ANGLE_Q;
	localparam logic signed [31:0] Q16_ONE = 32'sd1 <<< 16;

	typedef struct {
		rpc_op_t     op;
		logic [31:0] fa;   // x or magnitude
		logic [31:0] fb;   // y or angle in degrees
	} conv_req_t;

	logic         clk    = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata  = '0;
	logic         s_axis_tuser  = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	// CORDIC constants rebuilt here from the degrees-per-radian figure
	longint          atan_tab [32];
	longint unsigned inv_gain;

	conv_req_t   pending_reqs [$];
	conv_req_t   held_req;
	rpc_res_t    conv_expected [$];
	rpc_res_t    mon_got;
	rpc_res_t    mon_want;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          fails = 0;
	int          idle_cycles = 0;

	rect_polar_converter_top #(
		.CORDIC_ITERATIONS(ITERS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------------
	// fixed-point helpers
	// ---------------------------------------------------------------------

	// right shift rounding half toward +inf
	function automatic longint rshift_round(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint unsigned isqrt_u64(input longint unsigned n);
		longint unsigned rem;
		longint unsigned res;
		longint unsigned bitv;
		rem  = n;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// arctangent table in Q40 degrees and 1/K in Q30
	function automatic void build_cordic_consts();
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		longint unsigned r;
		longint unsigned p;
		longint unsigned root;
		longint unsigned term;
		longint          sum;
		int              i;
		int              k;
		num = 64'd572957795130823;
		den = 64'd10000000000000;
		q   = num / den;
		r   = num % den;
		// long division out to 56 fraction bits, then round
		for (i = 0; i < 56; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		if ((r << 1) >= den)
			q = q + 64'd1;
		atan_tab[0] = 64'sd45 <<< ANGLE_Q;
		for (i = 1; i < 32; i++) begin
			sum = 0;
			// atan series: sum (-1)^k * 2^-(i(2k+1)) / (2k+1)
			for (k = 0; i * (2 * k + 1) < 64; k++) begin
				term = (q >> (i * (2 * k + 1))) / longint'(2 * k + 1);
				if (k % 2)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			atan_tab[i] = rshift_round(sum, 16);
		end
		p = 64'd1 << 60;
		for (i = 0; i < ITERS && i < 32; i++)
			p = p + (p >> (2 * i));
		root     = isqrt_u64(p);
		inv_gain = ((64'd1 << 60) + root / 2) / root;
	endfunction

	// sign-magnitude Q30 multiply by 1/K, low half rounded
	function automatic longint gain_scale(input longint v);
		longint unsigned mag;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned res;
		mag = (v < 0) ? longint'(-v) : v;
		hi  = mag >> 32;
		lo  = mag & 64'hFFFF_FFFF;
		res = hi * inv_gain * 64'd4 + ((lo * inv_gain + (64'd1 << 29)) >> 30);
		return (v < 0) ? -longint'(res) : longint'(res);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// ---------------------------------------------------------------------
	// result predictor: one conversion per accepted word
	// ---------------------------------------------------------------------
	function automatic rpc_res_t conv_predict(input rpc_op_t op, input logic signed [31:0] fa,
			input logic signed [31:0] fb);
		rpc_res_t res;
		longint   a;
		longint   b;
		longint   xr;
		longint   yr;
		longint   mr;
		longint   ar;
		longint   vx;
		longint   vy;
		longint   z;
		longint   nx;
		int       i;
		a = fa;
		b = fb;
		if (op == OP_RECT) begin
			xr = a;
			yr = b;
			if (a == 0 && b == 0) begin
				// zero vector: no angle to speak of
				mr = 0;
				ar = 0;
			end else begin
				vx = a <<< GUARD_BITS;
				vy = b <<< GUARD_BITS;
				z  = 0;
				// left half plane: turn by 180 first so vectoring converges
				if (vx < 0) begin
					z  = (b >= 0) ? HALF_Z : -HALF_Z;
					vx = -vx;
					vy = -vy;
				end
				for (i = 0; i < ITERS; i++) begin
					if (vy >= 0) begin
						nx = vx + (vy >>> i);
						vy = vy - (vx >>> i);
						z  = z + atan_tab[i];
					end else begin
						nx = vx - (vy >>> i);
						vy = vy + (vx >>> i);
						z  = z - atan_tab[i];
					end
					vx = nx;
				end
				mr = rshift_round(gain_scale(vx), GUARD_BITS);
				ar = rshift_round(z, ANGLE_Q - FRAC_BITS);
				if (ar > HALF_TURN)
					ar = ar - FULL_TURN;
				if (ar <= -HALF_TURN)
					ar = ar + FULL_TURN;
			end
		end else begin
			// reduce angle to (-180, 180]
			ar = b % FULL_TURN;
			if (ar > HALF_TURN)
				ar = ar - FULL_TURN;
			if (ar <= -HALF_TURN)
				ar = ar + FULL_TURN;
			mr = a;
			z  = ar <<< (ANGLE_Q - FRAC_BITS);
			vx = a <<< GUARD_BITS;
			vy = 0;
			// beyond +-90: flip x and move the angle by 180
			if (z > QTR_Z) begin
				vx = -vx;
				z  = z - HALF_Z;
			end else if (z < -QTR_Z) begin
				vx = -vx;
				z  = z + HALF_Z;
			end
			vx = gain_scale(vx);
			for (i = 0; i < ITERS; i++) begin
				if (z >= 0) begin
					nx = vx - (vy >>> i);
					vy = vy + (vx >>> i);
					z  = z - atan_tab[i];
				end else begin
					nx = vx + (vy >>> i);
					vy = vy - (vx >>> i);
					z  = z + atan_tab[i];
				end
				vx = nx;
			end
			xr = clamp32(rshift_round(vx, GUARD_BITS));
			yr = clamp32(rshift_round(vy, GUARD_BITS));
		end
		res.x   = xr[31:0];
		res.y   = yr[31:0];
		res.mag = mr[32:0];
		res.ang = ar[24:0];
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------
	task automatic queue_req(input rpc_op_t op, input logic [31:0] fa, input logic [31:0] fb);
		conv_req_t rq;
		rq.op = op;
		rq.fa = fa;
		rq.fb = fb;
		pending_reqs.push_back(rq);
	endtask

	function automatic conv_req_t rand_req();
		conv_req_t   rq;
		logic [31:0] w;
		rq.op = rpc_op_t'($urandom_range(1));
		rq.fa = $urandom;
		rq.fb = $urandom;
		// first value: full range (saturation in polar) or moderate
		if ($urandom_range(1)) begin
			w     = $urandom;
			rq.fa = {{12{w[19]}}, w[19:0]};
		end
		if (rq.op == OP_POLAR) begin
			case ($urandom_range(3))
				0: ;   // any 32-bit angle
				1: rq.fb = $urandom_range(0, 32'd94371840) - 32'd47185920;   // +-720 deg
				2: rq.fb = ($urandom_range(0, 16) * 90 - 720) * 65536
						+ $urandom_range(0, 4) - 2;   // on or next to a quadrant edge
				default: begin
					w     = $urandom;
					rq.fb = {{12{w[19]}}, w[19:0]};
				end
			endcase
		end else begin
			case ($urandom_range(7))
				0: rq.fa = '0;                         // on the y axis
				1: rq.fb = '0;                         // on the x axis, either side
				2: if ($urandom_range(3) == 0) begin
					rq.fa = '0;                         // zero vector now and then
					rq.fb = '0;
				end
				3: begin
					w     = $urandom;
					rq.fb = {{12{w[19]}}, w[19:0]};
				end
				default: ;
			endcase
		end
		return rq;
	endfunction

	// ---------------------------------------------------------------------
	// driver: presents pending words, predicts each one as it is taken
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				conv_expected.push_back(conv_predict(held_req.op, held_req.fa, held_req.fb));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_req = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {held_req.fb, held_req.fa};
					s_axis_tuser  <= held_req.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: random backpressure, in-order field compare
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				mon_got = rpc_res_t'(m_axis_tdata[121:0]);
				if (conv_expected.size() == 0) begin
					$error("result word with nothing expected: %h", m_axis_tdata);
					fails++;
				end else begin
					mon_want = conv_expected.pop_front();
					if (mon_got.x !== mon_want.x) begin
						$error("x_out: expected %0d, got %0d", mon_want.x, mon_got.x);
						fails++;
					end
					if (mon_got.y !== mon_want.y) begin
						$error("y_out: expected %0d, got %0d", mon_want.y, mon_got.y);
						fails++;
					end
					if (mon_got.mag !== mon_want.mag) begin
						$error("magnitude_out: expected %0d, got %0d", mon_want.mag,
							mon_got.mag);
						fails++;
					end
					if (mon_got.ang !== mon_want.ang) begin
						$error("angle_out_deg: expected %0d, got %0d", mon_want.ang,
							mon_got.ang);
						fails++;
					end
					if (m_axis_tdata[127:122] !== 6'd0) begin
						$error("pad: expected 0, got %h", m_axis_tdata[127:122]);
						fails++;
					end
				end
			end
		end
	end

	// watchdog: stop if no word moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		int send_mix [4];
		int recv_mix [4];
		int ph;
		int n;
		send_mix = '{0, 46, 0, 38};
		recv_mix = '{0, 0, 46, 38};
		build_cordic_consts();

		// directed words, rectangular
		queue_req(OP_RECT, 32'd0, 32'd0);                       // zero vector
		queue_req(OP_RECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);       // largest positive x and y
		queue_req(OP_RECT, 32'h8000_0000, 32'h8000_0000);
		queue_req(OP_RECT, 32'h8000_0000, 32'h7FFF_FFFF);
		queue_req(OP_RECT, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_req(OP_RECT, -Q16_ONE, 32'd0);                    // negative x, y = 0: +180
		queue_req(OP_RECT, -Q16_ONE, -32'sd1);                  // just below -x axis
		queue_req(OP_RECT, -Q16_ONE, Q16_ONE);
		queue_req(OP_RECT, Q16_ONE, 32'd0);
		queue_req(OP_RECT, 32'd0, Q16_ONE);
		queue_req(OP_RECT, 32'd0, -Q16_ONE);
		queue_req(OP_RECT, 32'd1, 32'd0);                       // tiniest vectors
		queue_req(OP_RECT, 32'hFFFF_FFFF, 32'd0);
		// directed words, polar
		queue_req(OP_POLAR, Q16_ONE, 32'd0);
		queue_req(OP_POLAR, Q16_ONE, 32'sd90 <<< 16);
		queue_req(OP_POLAR, Q16_ONE, 32'sd180 <<< 16);
		queue_req(OP_POLAR, Q16_ONE, -(32'sd180 <<< 16));      // folds to +180
		queue_req(OP_POLAR, Q16_ONE, 32'sd360 <<< 16);
		queue_req(OP_POLAR, Q16_ONE, 32'sd270 <<< 16);
		queue_req(OP_POLAR, Q16_ONE, 32'sd135 <<< 16);          // beyond 90: x flipped
		queue_req(OP_POLAR, -Q16_ONE, 32'sd45 <<< 16);          // negative magnitude
		queue_req(OP_POLAR, 32'h8000_0000, 32'sd180 <<< 16);    // x saturates high
		queue_req(OP_POLAR, 32'h7FFF_FFFF, 32'd0);
		queue_req(OP_POLAR, Q16_ONE, 32'h7FFF_FFFF);            // angle extremes
		queue_req(OP_POLAR, 32'h7FFF_FFFF, 32'h8000_0000);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < 4; ph++) begin
			@(negedge clk);
			send_idle_pct  = send_mix[ph];
			recv_stall_pct = recv_mix[ph];
			for (n = 0; n < PHASE_WORDS; n++)
				pending_reqs.push_back(rand_req());
			while (pending_reqs.size() != 0 || s_axis_tvalid)
				@(posedge clk);
		end

		// drain, then give a stray word time to show up
		while (conv_expected.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ rect_polar_converter_top.f @@
rtl/rpc_pkg.sv
rtl/rpc_gain.sv
rtl/rpc_prep.sv
rtl/rpc_stage.sv
rtl/rpc_post.sv
rtl/rect_polar_converter_top.sv
rtl/rpc_checker.sv
test/tb_rect_polar_converter_top.sv
